// ===== hdl/segl_pkg.sv =====
// Shared constants, codes and payload types of the segment LCD frame store.
package segl_pkg;

    localparam int SEG_COUNT   = 32;
    localparam int ACTIVE_SEGS = (SEG_COUNT < 32) ? SEG_COUNT : 32;
    localparam int IDX_W       = (ACTIVE_SEGS > 1) ? $clog2(ACTIVE_SEGS) : 1;
    localparam int CNT_W       = $clog2(ACTIVE_SEGS + 1);
    localparam int ADDR_W      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] THRESHOLD_RESET = 8'd128;

    localparam logic [2:0] OP_SET       = 3'd0;
    localparam logic [2:0] OP_BLINK     = 3'd1;
    localparam logic [2:0] OP_REFRESH   = 3'd2;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
    localparam logic [2:0] OP_SET_ALL   = 3'd4;

    localparam logic [1:0] BLINK_OFF    = 2'd0;
    localparam logic [1:0] BLINK_IF_LIT = 2'd1;

    localparam logic [1:0] FRAME_WRITE   = 2'd0;
    localparam logic [1:0] FRAME_FILL    = 2'd1;
    localparam logic [1:0] FRAME_RESTART = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] position;
        logic [1:0] value;
        logic       force_update;
        logic [7:0] blink_count;
    } in_t;

    typedef struct packed {
        logic [1:0]        frame_kind;
        logic [ADDR_W-1:0] address;
        logic [3:0]        nibble;
        logic              blink_active;
        logic              last;
    } out_t;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_BLINK   = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_FILL    = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] seg;
        logic [3:0]       com;
        logic [1:0]       value;
        logic             force_update;
        logic             inverted;
        logic             fill_on;
    } cmd_t;

endpackage

// ===== hdl/segment_lcd_blink_framebuffer_core.sv =====
// Segment LCD frame store with blink and change tracking: top level.
// An accepted request is queued and runs once it heads the queue and the executor is idle;
// its frames go out through the result register. Set, blink and fill requests run in the idle
// state; a refresh that is not skipped scans one address per cycle over all 32 addresses,
// pausing while a held frame meets a stalled output, then sends any held final frame.
// Reset clears the store, shadow, blink flag and queue; the threshold register resets to 128.
module segment_lcd_blink_framebuffer_core import segl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    segl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    segl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop        (cmd_pop),
        .pop_cmd    (cmd)
    );

    segl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.frame_kind == FRAME_FILL))
        |-> (out_data.last && (out_data.address == '0) && !out_data.blink_active))
        else $error("malformed fill frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.frame_kind == FRAME_RESTART))
        |-> (out_data.last && out_data.blink_active && (out_data.nibble == 4'h0)))
        else $error("malformed blink restart frame");

endmodule

// ===== hdl/segl_front.sv =====
// Request intake: threshold register, decode and classification into commands.
module segl_front import segl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    logic [7:0] threshold_reg;
    logic [7:0] threshold_next;
    logic       keep;
    logic       seg_ok;
    logic [5:0] seg_wide;
    cmd_kind_t  kind_sel;

    assign cfg_ready      = 1'b1;
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign seg_wide = {1'b0, in_data.position[4:0]};
    assign seg_ok   = seg_wide < 6'(ACTIVE_SEGS);

    always_comb
    begin
        keep     = 1'b0;
        kind_sel = CMD_REFRESH;
        unique case (in_data.operation) inside
            OP_SET:
            begin
                keep     = seg_ok;
                kind_sel = CMD_SET;
            end
            OP_BLINK:
            begin
                keep     = seg_ok;
                kind_sel = CMD_BLINK;
            end
            OP_REFRESH:
            begin
                keep     = 1'b1;
                kind_sel = CMD_REFRESH;
            end
            OP_CLEAR_ALL, OP_SET_ALL:
            begin
                keep     = 1'b1;
                kind_sel = CMD_FILL;
            end
            default:
            begin
                keep     = 1'b0;
                kind_sel = CMD_REFRESH;
            end
        endcase
    end

    assign push_cmd.kind         = kind_sel;
    assign push_cmd.seg          = in_data.position[IDX_W-1:0];
    assign push_cmd.com          = 4'b0001 << in_data.position[7:6];
    assign push_cmd.value        = in_data.value;
    assign push_cmd.force_update = in_data.force_update;
    assign push_cmd.inverted     = in_data.blink_count >= threshold_reg;
    assign push_cmd.fill_on      = in_data.operation == OP_SET_ALL;

    assign in_ready   = push_ready;
    assign push_valid = in_valid && keep;

endmodule

// ===== hdl/segl_fifo.sv =====
// Short command queue between intake and execution.
module segl_fifo import segl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/segl_back.sv =====
// Command execution: frame store, sent shadow, refresh scan and result register.
module segl_back import segl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_pop,
    input  cmd_t cmd,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_TAIL = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [7:0]       pix_reg [ACTIVE_SEGS];
    logic [3:0]       shadow_reg [ACTIVE_SEGS];
    logic [CNT_W-1:0] blink_cnt_reg;
    logic [CNT_W-1:0] blink_cnt_next;
    logic             flag_reg;
    logic             flag_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             scan_inv_reg;
    logic             scan_force_reg;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic [IDX_W-1:0] pend_addr_reg;
    logic [3:0]       pend_nib_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_t             out_data_reg;
    out_t             out_data_next;

    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       cur_pix;
    logic [3:0]       cur_shadow;
    logic             out_can;
    logic             lit;
    logic             blink_on;
    logic [7:0]       set_pix;
    logic [7:0]       blink_pix;
    logic [7:0]       new_pix;
    logic             old_has;
    logic             new_has;
    logic             any_blink;
    logic             need_out;
    logic             go;
    logic             pix_we;
    logic             fill_we;
    logic [3:0]       fill_nib;
    logic             stage_en;
    logic [3:0]       want;
    logic             changed;
    logic             advance;
    logic             scan_last;
    logic             push;
    out_t             push_data;

    assign out_can    = !out_valid_reg || out_ready;
    assign rd_idx     = (state_reg == ST_SCAN) ? idx_reg : cmd.seg;
    assign cur_pix    = pix_reg[rd_idx];
    assign cur_shadow = shadow_reg[idx_reg];
    assign fill_nib   = cmd.fill_on ? 4'hf : 4'h0;
    assign any_blink  = blink_cnt_reg != '0;

    assign set_pix = ((cmd.value != BLINK_OFF) ? (cur_pix | {4'h0, cmd.com})
                                               : (cur_pix & ~{4'h0, cmd.com}))
                     & ~{cmd.com, 4'h0};
    assign lit       = (cur_pix[3:0] & cmd.com) != 4'h0;
    assign blink_on  = (cmd.value != BLINK_OFF) && !((cmd.value == BLINK_IF_LIT) && !lit);
    assign blink_pix = blink_on ? (cur_pix | {cmd.com, 4'h0}) : (cur_pix & ~{cmd.com, 4'h0});
    assign new_pix   = (cmd.kind == CMD_SET) ? set_pix : blink_pix;
    assign old_has   = cur_pix[7:4] != 4'h0;
    assign new_has   = new_pix[7:4] != 4'h0;

    assign need_out = (cmd.kind == CMD_FILL)
                   || ((cmd.kind == CMD_BLINK) && blink_on && !flag_reg);
    assign go       = (state_reg == ST_IDLE) && cmd_valid && (!need_out || out_can);
    assign cmd_pop  = go;
    assign pix_we   = go && ((cmd.kind == CMD_SET) || (cmd.kind == CMD_BLINK));
    assign fill_we  = go && (cmd.kind == CMD_FILL);

    assign stage_en  = !scan_inv_reg || (cur_pix[7:4] != 4'h0) || scan_force_reg;
    assign want      = scan_inv_reg ? (cur_pix[3:0] ^ cur_pix[7:4]) : cur_pix[3:0];
    assign changed   = stage_en && (cur_shadow != want);
    assign advance   = (state_reg == ST_SCAN) && !(changed && pend_valid_reg && !out_can);
    assign scan_last = idx_reg == IDX_W'(ACTIVE_SEGS - 1);

    always_comb
    begin
        state_next      = state_reg;
        blink_cnt_next  = blink_cnt_reg;
        flag_next       = flag_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        push_data       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    unique case (cmd.kind)
                        CMD_SET:
                        begin
                            if (new_has && !old_has)
                            begin
                                blink_cnt_next = blink_cnt_reg + 1'b1;
                            end
                            else if (old_has && !new_has)
                            begin
                                blink_cnt_next = blink_cnt_reg - 1'b1;
                            end
                        end
                        CMD_BLINK:
                        begin
                            if (new_has && !old_has)
                            begin
                                blink_cnt_next = blink_cnt_reg + 1'b1;
                            end
                            else if (old_has && !new_has)
                            begin
                                blink_cnt_next = blink_cnt_reg - 1'b1;
                            end
                            if (blink_on && !flag_reg)
                            begin
                                flag_next               = 1'b1;
                                push                    = 1'b1;
                                push_data.frame_kind    = FRAME_RESTART;
                                push_data.blink_active  = 1'b1;
                                push_data.last          = 1'b1;
                            end
                        end
                        CMD_REFRESH:
                        begin
                            if (cmd.inverted && !any_blink)
                            begin
                                flag_next = 1'b0;
                            end
                            if (!cmd.inverted || any_blink || cmd.force_update)
                            begin
                                state_next      = ST_SCAN;
                                idx_next        = '0;
                                pend_valid_next = 1'b0;
                            end
                        end
                        CMD_FILL:
                        begin
                            blink_cnt_next         = '0;
                            flag_next              = 1'b0;
                            push                   = 1'b1;
                            push_data.frame_kind   = FRAME_FILL;
                            push_data.nibble       = fill_nib;
                            push_data.blink_active = 1'b0;
                            push_data.last         = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (changed && pend_valid_reg && out_can)
                begin
                    push                   = 1'b1;
                    push_data.frame_kind   = FRAME_WRITE;
                    push_data.address      = ADDR_W'(pend_addr_reg);
                    push_data.nibble       = pend_nib_reg;
                    push_data.blink_active = flag_reg;
                    push_data.last         = 1'b0;
                end
                if (advance)
                begin
                    if (changed)
                    begin
                        pend_valid_next = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (scan_last)
                    begin
                        idx_next   = '0;
                        state_next = (pend_valid_reg || changed) ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_can)
                begin
                    push                   = 1'b1;
                    push_data.frame_kind   = FRAME_WRITE;
                    push_data.address      = ADDR_W'(pend_addr_reg);
                    push_data.nibble       = pend_nib_reg;
                    push_data.blink_active = flag_reg;
                    push_data.last         = 1'b1;
                    pend_valid_next        = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_data_next  = push ? push_data : out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            blink_cnt_reg  <= '0;
            flag_reg       <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            blink_cnt_reg  <= blink_cnt_next;
            flag_reg       <= flag_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACTIVE_SEGS; i++)
            begin
                pix_reg[i]    <= 8'h00;
                shadow_reg[i] <= 4'h0;
            end
        end
        else if (fill_we)
        begin
            for (int i = 0; i < ACTIVE_SEGS; i++)
            begin
                pix_reg[i]    <= {4'h0, fill_nib};
                shadow_reg[i] <= fill_nib;
            end
        end
        else
        begin
            if (pix_we)
            begin
                pix_reg[cmd.seg] <= new_pix;
            end
            if (advance && changed)
            begin
                shadow_reg[idx_reg] <= want;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (go && (cmd.kind == CMD_REFRESH))
        begin
            scan_inv_reg   <= cmd.inverted;
            scan_force_reg <= cmd.force_update;
        end
        if (advance && changed)
        begin
            pend_addr_reg <= idx_reg;
            pend_nib_reg  <= want;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== bench/segl_frame_checker.sv =====
// Frame checker for the segment LCD frame store: watches the channels, predicts and compares.
module segl_frame_checker import segl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_t        in_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_t       out_data,
    output int         pending_frames,
    output int         frames_checked,
    output int         mismatch_count
);

    logic [7:0]             threshold;
    logic [7:0]             cells [ACTIVE_SEGS];
    logic [3:0]             shown [ACTIVE_SEGS];
    logic [ACTIVE_SEGS-1:0] unsent;
    logic                   blinking;
    out_t                   frame_queue [$];

    task automatic queue_frame(input logic [1:0] kind, input int addr, input logic [3:0] nib,
                               input logic fin);
        out_t f;
        f.frame_kind   = kind;
        f.address      = ADDR_W'(addr);
        f.nibble       = nib;
        f.blink_active = blinking;
        f.last         = fin;
        frame_queue.push_back(f);
    endtask

    task automatic stage_nibble(input int idx, input logic [3:0] want);
        if (shown[idx] != want)
        begin
            shown[idx]  = want;
            unsent[idx] = 1'b1;
        end
    endtask

    task automatic predict_request(input in_t req);
        int         seg;
        int         top_dirty;
        logic [3:0] com;
        logic [3:0] v;
        logic [3:0] b;
        logic [3:0] fill;
        logic       inverted;
        logic       any_blink;
        seg = int'(req.position[4:0]);
        com = 4'b0001 << req.position[7:6];
        case (req.operation) inside
            OP_SET:
            begin
                if (seg < ACTIVE_SEGS)
                begin
                    if (|req.value)
                        cells[seg][3:0] = cells[seg][3:0] | com;
                    else
                        cells[seg][3:0] = cells[seg][3:0] & ~com;
                    cells[seg][7:4] = cells[seg][7:4] & ~com;
                end
            end
            OP_BLINK:
            begin
                if (seg < ACTIVE_SEGS)
                begin
                    if (req.value != BLINK_OFF &&
                        !(req.value == BLINK_IF_LIT && (cells[seg][3:0] & com) == 4'd0))
                    begin
                        cells[seg][7:4] = cells[seg][7:4] | com;
                        if (!blinking)
                        begin
                            blinking = 1'b1;
                            queue_frame(FRAME_RESTART, 0, 4'd0, 1'b1);
                        end
                    end
                    else
                        cells[seg][7:4] = cells[seg][7:4] & ~com;
                end
            end
            OP_REFRESH:
            begin
                inverted  = req.blink_count >= threshold;
                any_blink = 1'b0;
                for (int i = 0; i < ACTIVE_SEGS; i++)
                begin
                    v = cells[i][3:0];
                    b = cells[i][7:4];
                    if (!inverted)
                        stage_nibble(i, v);
                    else if (b == 4'd0)
                    begin
                        if (req.force_update)
                            stage_nibble(i, v);
                    end
                    else
                    begin
                        stage_nibble(i, v ^ b);
                        any_blink = 1'b1;
                    end
                end
                if (inverted && !any_blink)
                    blinking = 1'b0;
                if (!inverted || any_blink || req.force_update)
                begin
                    top_dirty = -1;
                    for (int i = 0; i < ACTIVE_SEGS; i++)
                        if (unsent[i])
                            top_dirty = i;
                    for (int i = 0; i < ACTIVE_SEGS; i++)
                        if (unsent[i])
                            queue_frame(FRAME_WRITE, i, shown[i], i == top_dirty);
                    unsent = '0;
                end
            end
            OP_CLEAR_ALL, OP_SET_ALL:
            begin
                fill = (req.operation == OP_SET_ALL) ? 4'hf : 4'h0;
                for (int i = 0; i < ACTIVE_SEGS; i++)
                begin
                    cells[i] = {4'h0, fill};
                    shown[i] = fill;
                end
                unsent   = '0;
                blinking = 1'b0;
                queue_frame(FRAME_FILL, 0, fill, 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        out_t want;
        if (!rst_n)
        begin
            threshold = THRESHOLD_RESET;
            for (int i = 0; i < ACTIVE_SEGS; i++)
            begin
                cells[i] = 8'd0;
                shown[i] = 4'd0;
            end
            unsent         = '0;
            blinking       = 1'b0;
            frames_checked = 0;
            mismatch_count = 0;
            frame_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (out_valid && out_ready)
            begin
                frames_checked++;
                if (frame_queue.size() == 0)
                begin
                    $error("unexpected frame: kind %0d address %0d nibble %0d",
                           out_data.frame_kind, out_data.address, out_data.nibble);
                    mismatch_count++;
                end
                else
                begin
                    want = frame_queue.pop_front();
                    check_field("frame_kind", want.frame_kind, out_data.frame_kind);
                    check_field("address", want.address, out_data.address);
                    check_field("nibble", want.nibble, out_data.nibble);
                    check_field("blink_active", want.blink_active, out_data.blink_active);
                    check_field("last", want.last, out_data.last);
                end
            end
            if (in_valid && in_ready)
                predict_request(in_data);
        end
        pending_frames <= frame_queue.size();
    end

endmodule

// ===== bench/tb_segment_lcd_blink_framebuffer_core.sv =====
// Testbench top for the segment LCD frame store: stimulus, threshold phases and verdict.
module tb_segment_lcd_blink_framebuffer_core;
    import segl_pkg::*;

    localparam logic [2:0] OP_SPARE_LOW    = 3'd5;
    localparam logic [2:0] OP_SPARE_HIGH   = 3'd7;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES    = 80;
    localparam int         PHASE_ITEMS     = 32;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_t        in_data   = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_t       out_data;

    int         pending_frames;
    int         frames_checked;
    int         mismatch_count;
    int         requests_sent  = 0;
    int         refreshes_sent = 0;
    int         settings_used  = 0;
    int         hold_asks      = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;
    bit         steady         = 1'b0;
    logic [7:0] threshold_now  = THRESHOLD_RESET;

    segment_lcd_blink_framebuffer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    segl_frame_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .pending_frames (pending_frames),
        .frames_checked (frames_checked),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("[segment_lcd_blink_framebuffer_core] ERROR");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    function automatic in_t make_request(input logic [2:0] op, input logic [7:0] pos,
                                         input logic [1:0] val, input logic frc,
                                         input logic [7:0] cnt);
        in_t r;
        r.operation    = op;
        r.position     = pos;
        r.value        = val;
        r.force_update = frc;
        r.blink_count  = cnt;
        return r;
    endfunction

    function automatic logic [7:0] pick_count();
        int c;
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        c = int'(threshold_now) + int'($urandom_range(0, 6)) - 3;
        if (c < 0)
            c = 0;
        if (c > 255)
            c = 255;
        return 8'(c);
    endfunction

    function automatic in_t random_request();
        int         pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_SET;
        else if (pick < 55)
            op = OP_BLINK;
        else if (pick < 85)
            op = OP_REFRESH;
        else if (pick < 90)
            op = OP_CLEAR_ALL;
        else if (pick < 95)
            op = OP_SET_ALL;
        else
            op = 3'($urandom_range(OP_SPARE_LOW, OP_SPARE_HIGH));
        return make_request(op, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), pick_count());
    endfunction

    task automatic send_request(input in_t req);
        if (!steady && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
        if (req.operation == OP_REFRESH)
            refreshes_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_frames != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] t);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        threshold_now = t;
        settings_used++;
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_request(random_request());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(OP_SET, 8'h00, 2'd1, 1'b0, 8'd0));
        send_request(make_request(OP_SET, 8'hff, 2'd3, 1'b1, 8'd255));
        send_request(make_request(OP_SET, 8'h65, 2'd2, 1'b0, 8'd17));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b0, 8'd0));
        send_request(make_request(OP_REFRESH, 8'hff, 2'd3, 1'b1, 8'd127));
        send_request(make_request(OP_BLINK, 8'h87, BLINK_IF_LIT, 1'b0, 8'd0));
        send_request(make_request(OP_BLINK, 8'h00, BLINK_IF_LIT, 1'b0, 8'd0));
        send_request(make_request(OP_BLINK, 8'h8a, 2'd2, 1'b0, 8'd0));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b0, 8'd255));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b0, 8'd128));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b0, 8'd127));
        send_request(make_request(OP_SET, 8'h8a, 2'd0, 1'b0, 8'd0));
        send_request(make_request(OP_BLINK, 8'h00, BLINK_OFF, 1'b0, 8'd0));
        send_request(make_request(OP_SET, 8'h40, 2'd1, 1'b0, 8'd0));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b0, 8'd200));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b1, 8'd200));
        send_request(make_request(OP_SPARE_LOW, 8'hff, 2'd3, 1'b1, 8'd255));
        send_request(make_request(3'(OP_SPARE_LOW + 3'd1), 8'h21, 2'd1, 1'b0, 8'd0));
        send_request(make_request(OP_SPARE_HIGH, 8'h00, 2'd2, 1'b1, 8'd128));
        send_request(make_request(OP_SET_ALL, 8'h00, 2'd0, 1'b0, 8'd0));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b1, 8'd0));
        send_request(make_request(OP_BLINK, 8'hdf, 2'd3, 1'b0, 8'd0));
        send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b1, 8'd255));
        send_request(make_request(OP_CLEAR_ALL, 8'h00, 2'd0, 1'b0, 8'd0));
        settle();

        write_threshold(8'd0);
        random_phase(PHASE_ITEMS);
        settle();

        write_threshold(8'd255);
        random_phase(PHASE_ITEMS);
        settle();

        write_threshold(8'($urandom_range(1, 254)));
        hold_asks++;
        for (int k = 0; k < 16; k++)
        begin
            if (k % 2 == 0)
                send_request(make_request((k % 4 == 0) ? OP_SET_ALL : OP_CLEAR_ALL,
                                          8'($urandom_range(0, 255)), 2'd0, 1'b0, 8'd0));
            else
                send_request(make_request(OP_REFRESH, 8'h00, 2'd0, 1'b1, pick_count()));
        end
        random_phase(PHASE_ITEMS - 16);
        settle();

        write_threshold(THRESHOLD_RESET);
        steady = 1'b1;
        random_phase(PHASE_ITEMS);
        steady = 1'b0;
        settle();

        $display("Run covered %0d requests, %0d of them refreshes, over %0d threshold settings.",
                 requests_sent, refreshes_sent, settings_used);
        $display("Frames compared: %0d, mismatches: %0d.", frames_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[segment_lcd_blink_framebuffer_core] OK");
        else
            $display("[segment_lcd_blink_framebuffer_core] ERROR");
        $finish;
    end

endmodule
